/* rtl/assert_macros.svh */
// Assertion helpers included by the core RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RV32EU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define RV32EU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/rv32eu_pkg.sv */
package rv32eu_pkg;

    // Register file geometry.
    localparam int RegCount = 32;
    localparam int RegAw    = $clog2(RegCount);

    // Bus request codes.
    localparam logic [1:0] MemNone  = 2'd0;
    localparam logic [1:0] MemRead  = 2'd1;
    localparam logic [1:0] MemWrite = 2'd2;

    // Result status codes.
    localparam logic [2:0] StDone     = 3'd0;
    localparam logic [2:0] StUnknown  = 3'd1;
    localparam logic [2:0] StLoadDone = 3'd2;
    localparam logic [2:0] StUnexp    = 3'd3;
    localparam logic [2:0] StBusy     = 3'd4;

    // One input item.
    typedef struct packed {
        logic        kind;
        logic [31:0] instruction_word;
        logic [31:0] load_data;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [31:0] next_pc;
        logic [1:0]  mem_op;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [1:0]  mem_size;
        logic        dest_written;
        logic [4:0]  dest_reg;
        logic [31:0] dest_value;
        logic [2:0]  status;
    } t_out_item;

    // Outstanding load bookkeeping.
    typedef struct packed {
        logic       pending;
        logic [4:0] dest;
        logic [2:0] ltype;
    } t_load_ctl;

    // True for a register index that is backed by storage (not x0, within range).
    function automatic logic reg_ok(input logic [4:0] idx);
        return (idx != 5'd0) && ({1'b0, idx} < 6'(RegCount));
    endfunction

endpackage

/* rtl/rv32eu_exec.sv */
module rv32eu_exec (
    input  rv32eu_pkg::t_in_item  i_item,
    input  logic [31:0]           i_a,
    input  logic [31:0]           i_b,
    input  logic [31:0]           i_pc,
    input  rv32eu_pkg::t_load_ctl i_load,
    output rv32eu_pkg::t_out_item o_result,
    output rv32eu_pkg::t_load_ctl o_load
);

    // Major opcodes.
    localparam logic [6:0] OpReg    = 7'b0110011;
    localparam logic [6:0] OpImm    = 7'b0010011;
    localparam logic [6:0] OpLoad   = 7'b0000011;
    localparam logic [6:0] OpStore  = 7'b0100011;
    localparam logic [6:0] OpBranch = 7'b1100011;
    localparam logic [6:0] OpJal    = 7'b1101111;
    localparam logic [6:0] OpJalr   = 7'b1100111;
    localparam logic [6:0] OpLui    = 7'b0110111;
    localparam logic [6:0] OpAuipc  = 7'b0010111;
    localparam logic [6:0] OpFence  = 7'b0001111;

    localparam logic [6:0] F7Zero = 7'h00;
    localparam logic [6:0] F7Alt  = 7'h20;

    // ALU funct3 codes.
    localparam logic [2:0] F3AddSub = 3'd0;
    localparam logic [2:0] F3Sll    = 3'd1;
    localparam logic [2:0] F3Slt    = 3'd2;
    localparam logic [2:0] F3Sltu   = 3'd3;
    localparam logic [2:0] F3Xor    = 3'd4;
    localparam logic [2:0] F3Srx    = 3'd5;
    localparam logic [2:0] F3Or     = 3'd6;
    localparam logic [2:0] F3And    = 3'd7;

    // Branch funct3 codes.
    localparam logic [2:0] F3Beq  = 3'd0;
    localparam logic [2:0] F3Bne  = 3'd1;
    localparam logic [2:0] F3Blt  = 3'd4;
    localparam logic [2:0] F3Bge  = 3'd5;
    localparam logic [2:0] F3Bltu = 3'd6;
    localparam logic [2:0] F3Bgeu = 3'd7;

    // Load and store funct3 codes; a store's funct3 is also its size code.
    localparam logic [2:0] F3Lb  = 3'd0;
    localparam logic [2:0] F3Lh  = 3'd1;
    localparam logic [2:0] F3Lw  = 3'd2;
    localparam logic [2:0] F3Lbu = 3'd4;
    localparam logic [2:0] F3Lhu = 3'd5;
    localparam logic [2:0] F3Base = 3'd0;

    localparam logic [1:0] SizeByte = 2'd0;
    localparam logic [1:0] SizeHalf = 2'd1;
    localparam logic [1:0] SizeWord = 2'd2;

    logic [31:0] w;
    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] immi;
    logic [31:0] imms;
    logic [31:0] immb;
    logic [31:0] immj;
    logic [31:0] immu;
    logic [31:0] pc4;
    logic        is_reg;
    logic [31:0] bop;
    logic [31:0] alu_v;
    logic        alu_ok;
    logic        take;
    logic        br_ok;
    logic        has_dest;
    logic        ok;
    logic [31:0] v;
    logic [4:0]  dst;

    // Instruction fields and immediates.
    assign w      = i_item.instruction_word;
    assign op     = w[6:0];
    assign rd     = w[11:7];
    assign f3     = w[14:12];
    assign f7     = w[31:25];
    assign immi   = {{20{w[31]}}, w[31:20]};
    assign imms   = {{20{w[31]}}, w[31:25], w[11:7]};
    assign immb   = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign immj   = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    assign immu   = {w[31:12], 12'd0};
    assign pc4    = i_pc + 32'd4;
    assign is_reg = (op == OpReg);

    // Second ALU operand: register, shift amount or I-type immediate.
    always_comb begin
        if (is_reg) begin
            bop = i_b;
        end else if (f3 == F3Sll || f3 == F3Srx) begin
            bop = {27'd0, w[24:20]};
        end else begin
            bop = immi;
        end
    end

    // ALU for register and immediate forms.
    always_comb begin
        alu_ok = 1'b1;
        alu_v  = '0;
        case (f3)
            F3AddSub: begin
                if (!is_reg || f7 == F7Zero) begin
                    alu_v = i_a + bop;
                end else if (f7 == F7Alt) begin
                    alu_v = i_a - bop;
                end else begin
                    alu_ok = 1'b0;
                end
            end
            F3Sll: begin
                if (f7 == F7Zero) begin
                    alu_v = i_a << bop[4:0];
                end else begin
                    alu_ok = 1'b0;
                end
            end
            F3Srx: begin
                if (f7 == F7Zero) begin
                    alu_v = i_a >> bop[4:0];
                end else if (f7 == F7Alt) begin
                    alu_v = $unsigned($signed(i_a) >>> bop[4:0]);
                end else begin
                    alu_ok = 1'b0;
                end
            end
            default: begin
                if (!is_reg || f7 == F7Zero) begin
                    case (f3)
                        F3Slt:   alu_v = {31'd0, $signed(i_a) < $signed(bop)};
                        F3Sltu:  alu_v = {31'd0, i_a < bop};
                        F3Xor:   alu_v = i_a ^ bop;
                        F3Or:    alu_v = i_a | bop;
                        F3And:   alu_v = i_a & bop;
                        default: alu_v = '0;
                    endcase
                end else begin
                    alu_ok = 1'b0;
                end
            end
        endcase
    end

    // Branch condition.
    always_comb begin
        br_ok = 1'b1;
        case (f3)
            F3Beq:   take = (i_a == i_b);
            F3Bne:   take = (i_a != i_b);
            F3Blt:   take = ($signed(i_a) < $signed(i_b));
            F3Bge:   take = ($signed(i_a) >= $signed(i_b));
            F3Bltu:  take = (i_a < i_b);
            F3Bgeu:  take = (i_a >= i_b);
            default: begin
                take  = 1'b0;
                br_ok = 1'b0;
            end
        endcase
    end

    // Item execution: load return, busy, or one instruction.
    always_comb begin
        o_result         = '0;
        o_result.next_pc = pc4;
        o_result.status  = rv32eu_pkg::StDone;
        o_load           = i_load;
        has_dest         = 1'b0;
        ok               = 1'b1;
        v                = '0;
        dst              = rd;

        if (i_item.kind) begin
            o_result.next_pc = i_pc;
            if (!i_load.pending) begin
                o_result.status = rv32eu_pkg::StUnexp;
            end else begin
                case (i_load.ltype)
                    F3Lb:    v = {{24{i_item.load_data[7]}}, i_item.load_data[7:0]};
                    F3Lh:    v = {{16{i_item.load_data[15]}}, i_item.load_data[15:0]};
                    F3Lbu:   v = {24'd0, i_item.load_data[7:0]};
                    F3Lhu:   v = {16'd0, i_item.load_data[15:0]};
                    default: v = i_item.load_data;
                endcase
                dst             = i_load.dest;
                has_dest        = 1'b1;
                o_load.pending  = 1'b0;
                o_result.status = rv32eu_pkg::StLoadDone;
            end
        end else if (i_load.pending) begin
            o_result.next_pc = i_pc;
            o_result.status  = rv32eu_pkg::StBusy;
        end else begin
            case (op)
                OpReg, OpImm: begin
                    v        = alu_v;
                    has_dest = alu_ok;
                    ok       = alu_ok;
                end
                OpLui: begin
                    v        = immu;
                    has_dest = 1'b1;
                end
                OpAuipc: begin
                    v        = i_pc + immu;
                    has_dest = 1'b1;
                end
                OpJal: begin
                    o_result.next_pc = i_pc + immj;
                    v                = pc4;
                    has_dest         = 1'b1;
                end
                OpJalr: begin
                    if (f3 == F3Base) begin
                        o_result.next_pc = (i_a + immi) & ~32'd1;
                        v                = pc4;
                        has_dest         = 1'b1;
                    end else begin
                        ok = 1'b0;
                    end
                end
                OpBranch: begin
                    ok = br_ok;
                    if (take) begin
                        o_result.next_pc = i_pc + immb;
                    end
                end
                OpLoad: begin
                    if (f3 inside {F3Lb, F3Lh, F3Lw, F3Lbu, F3Lhu}) begin
                        o_result.mem_op      = rv32eu_pkg::MemRead;
                        o_result.mem_address = i_a + immi;
                        o_result.mem_size    = f3[1:0];
                        o_load.pending       = 1'b1;
                        o_load.dest          = rd;
                        o_load.ltype         = f3;
                    end else begin
                        ok = 1'b0;
                    end
                end
                OpStore: begin
                    if (f3[2] == 1'b0 && f3[1:0] != 2'd3) begin
                        o_result.mem_op      = rv32eu_pkg::MemWrite;
                        o_result.mem_address = i_a + imms;
                        o_result.mem_size    = f3[1:0];
                        case (f3[1:0])
                            SizeByte: o_result.mem_write_data = {24'd0, i_b[7:0]};
                            SizeHalf: o_result.mem_write_data = {16'd0, i_b[15:0]};
                            SizeWord: o_result.mem_write_data = i_b;
                            default:  o_result.mem_write_data = '0;
                        endcase
                    end else begin
                        ok = 1'b0;
                    end
                end
                OpFence: begin
                    ok = (f3 == F3Base);
                end
                default: begin
                    ok = 1'b0;
                end
            endcase

            // Unknown instruction: drop every side effect and step past it.
            if (!ok) begin
                o_result.next_pc        = pc4;
                o_result.mem_op         = rv32eu_pkg::MemNone;
                o_result.mem_address    = '0;
                o_result.mem_size       = '0;
                o_result.mem_write_data = '0;
                o_result.status         = rv32eu_pkg::StUnknown;
                o_load                  = i_load;
                has_dest                = 1'b0;
            end
        end

        // Destination write; x0 and unbacked indices are never written.
        if (has_dest && rv32eu_pkg::reg_ok(dst)) begin
            o_result.dest_written = 1'b1;
            o_result.dest_reg     = dst;
            o_result.dest_value   = v;
        end
    end

endmodule

/* rtl/rv32execute_unit_core.sv */
// The register read and the item are captured into stage 1 on the accepting edge, and execute
// loads the output register when stage 1 advances.
// Throughput: one item per cycle while the output is not stalled; the next item's register read
// overlaps the current item's execute, with the same-cycle write forwarded from a bypass register.
// Reset (synchronous, active low): program counter 0, no load pending, and every register reads
// zero through per-entry valid bits, so no clearing pass is needed.
`include "assert_macros.svh"

module rv32i_execute_unit_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  rv32eu_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output rv32eu_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [31:0]           i_cfg_data
);

    logic [31:0]                  r_rf_mem [rv32eu_pkg::RegCount];
    logic [rv32eu_pkg::RegCount-1:0] r_vld;

    logic                         r_s1_valid;
    rv32eu_pkg::t_in_item         r_s1_item;
    logic [31:0]                  r_rd_a;
    logic [31:0]                  r_rd_b;
    logic                         r_a_ok;
    logic                         r_b_ok;
    logic                         r_fw_en;
    logic [4:0]                   r_fw_idx;
    logic [31:0]                  r_fw_data;
    logic                         r_out_valid;
    rv32eu_pkg::t_out_item        r_out_item;
    logic [31:0]                  r_pc;
    rv32eu_pkg::t_load_ctl        r_load;

    rv32eu_pkg::t_load_ctl        n_load;
    rv32eu_pkg::t_out_item        res;
    logic                         accept;
    logic                         s1_adv;
    logic                         out_take;
    logic                         cfg_we;
    logic                         wr_en;
    logic [rv32eu_pkg::RegAw-1:0] wr_idx;
    logic [4:0]                   in_rs1;
    logic [4:0]                   in_rs2;
    logic [rv32eu_pkg::RegAw-1:0] in_rs1_idx;
    logic [rv32eu_pkg::RegAw-1:0] in_rs2_idx;
    logic [4:0]                   s1_rs1;
    logic [4:0]                   s1_rs2;
    logic [31:0]                  op_a;
    logic [31:0]                  op_b;

    // Handshakes: the output register frees stage 1, which frees the input.
    assign out_take    = r_out_valid && !i_out_stall;
    assign s1_adv      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !s1_adv;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Source register indices of the incoming and the executing item.
    assign in_rs1     = i_in_item.instruction_word[19:15];
    assign in_rs2     = i_in_item.instruction_word[24:20];
    assign in_rs1_idx = in_rs1[rv32eu_pkg::RegAw-1:0];
    assign in_rs2_idx = in_rs2[rv32eu_pkg::RegAw-1:0];
    assign s1_rs1     = r_s1_item.instruction_word[19:15];
    assign s1_rs2     = r_s1_item.instruction_word[24:20];

    // Operands: bypass the write made on the read edge, else memory data if valid.
    always_comb begin
        if (r_fw_en && r_fw_idx == s1_rs1) begin
            op_a = r_fw_data;
        end else begin
            op_a = r_a_ok ? r_rd_a : '0;
        end
        if (r_fw_en && r_fw_idx == s1_rs2) begin
            op_b = r_fw_data;
        end else begin
            op_b = r_b_ok ? r_rd_b : '0;
        end
    end

    rv32eu_exec u_exec (
        .i_item   (r_s1_item),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_pc     (r_pc),
        .i_load   (r_load),
        .o_result (res),
        .o_load   (n_load)
    );

    assign wr_en  = s1_adv && res.dest_written;
    assign wr_idx = res.dest_reg[rv32eu_pkg::RegAw-1:0];

    // Register file memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rf_mem[wr_idx] <= res.dest_value;
        end
        if (accept) begin
            r_rd_a <= r_rf_mem[in_rs1_idx];
            r_rd_b <= r_rf_mem[in_rs2_idx];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_load      <= '0;
            r_vld       <= '0;
            r_fw_en     <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fw_en    <= wr_en;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_we) begin
                r_pc <= i_cfg_data;
            end else if (s1_adv) begin
                r_pc <= res.next_pc;
            end
            if (s1_adv) begin
                r_load <= n_load;
            end
            if (wr_en) begin
                r_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Item payload, read qualifiers and bypass data.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_item;
            r_a_ok    <= rv32eu_pkg::reg_ok(in_rs1) && r_vld[in_rs1_idx];
            r_b_ok    <= rv32eu_pkg::reg_ok(in_rs2) && r_vld[in_rs2_idx];
            r_fw_idx  <= res.dest_reg;
            r_fw_data <= res.dest_value;
        end
        if (s1_adv) begin
            r_out_item <= res;
        end
    end

    // Checks on the execute stage.
    `RV32EU_ASSERT_IMPLY(a_no_x0_write, i_clk, i_rst_n, wr_en, res.dest_reg != 5'd0)
    `RV32EU_ASSERT_NEXT(a_busy_holds_pc, i_clk, i_rst_n, s1_adv && !r_s1_item.kind && r_load.pending && !cfg_we, r_pc == $past(r_pc))
    `RV32EU_ASSERT_NEXT(a_load_done_clears, i_clk, i_rst_n, s1_adv && r_s1_item.kind, !r_load.pending)
    `RV32EU_ASSERT_IMPLY(a_read_no_dest, i_clk, i_rst_n, s1_adv && res.mem_op == rv32eu_pkg::MemRead, !res.dest_written)

endmodule

/* test/rv32i_execute_unit_core_tb.sv */
`timescale 1ns / 1ps

module rv32i_execute_unit_core_tb;

    // Opcodes of the base integer set.
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;

    // Function codes.
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SH   = 3'd1;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [31:0] WORD_ECALL = 32'h0000_0073;

    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 166;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 400000;

    // Directed stimulus row; fixed holds a hand-written expectation when typed is set.
    typedef struct {
        rv32eu_pkg::t_in_item  item;
        logic                  typed;
        rv32eu_pkg::t_out_item fixed;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    rv32eu_pkg::t_in_item  i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    rv32eu_pkg::t_out_item o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [31:0]           i_cfg_data;

    // Architectural state mirrored by the predictor.
    logic [31:0] gpr [32];
    logic [31:0] cur_pc;
    logic        ld_wait;
    logic [4:0]  ld_rd;
    logic [2:0]  ld_f3;

    rv32eu_pkg::t_out_item pending_results[$];
    t_stim_row             dir_rows[$];
    int                    mismatches;
    int unsigned           cycles;
    logic                  calm;

    rv32i_execute_unit_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Instruction encoders.
    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_REG};
    endfunction

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
    endfunction

    function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                          input logic [6:0] opc);
        return {imm, rd, opc};
    endfunction

    // Result with everything zero except the program counter and the status.
    function automatic rv32eu_pkg::t_out_item simple_result(input logic [31:0] pc,
                                                            input logic [2:0] st);
        rv32eu_pkg::t_out_item r;
        r = '0;
        r.next_pc = pc;
        r.status  = st;
        return r;
    endfunction

    // Register and immediate ALU; ok drops for an undefined funct3/funct7 pair.
    function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic [6:0] f7,
                                             input logic is_reg, input logic [31:0] a,
                                             input logic [31:0] b, output logic ok);
        logic [4:0] sh;
        logic       plain;
        sh    = b[4:0];
        plain = !is_reg || f7 == F7_BASE;
        ok    = 1'b1;
        alu_calc = '0;
        case (f3)
            F3_ADD: begin
                if (plain) alu_calc = a + b;
                else if (f7 == F7_ALT) alu_calc = a - b;
                else ok = 1'b0;
            end
            F3_SLL: begin
                if (f7 == F7_BASE) alu_calc = a << sh;
                else ok = 1'b0;
            end
            F3_SLT: begin
                if (plain) alu_calc = {31'd0, $signed(a) < $signed(b)};
                else ok = 1'b0;
            end
            F3_SLTU: begin
                if (plain) alu_calc = {31'd0, a < b};
                else ok = 1'b0;
            end
            F3_XOR: begin
                if (plain) alu_calc = a ^ b;
                else ok = 1'b0;
            end
            F3_SR: begin
                if (f7 == F7_BASE) alu_calc = a >> sh;
                else if (f7 == F7_ALT) alu_calc = $unsigned($signed(a) >>> sh);
                else ok = 1'b0;
            end
            F3_OR: begin
                if (plain) alu_calc = a | b;
                else ok = 1'b0;
            end
            default: begin
                if (plain) alu_calc = a & b;
                else ok = 1'b0;
            end
        endcase
    endfunction

    // Executes one accepted item against the mirrored state and returns its result.
    function automatic rv32eu_pkg::t_out_item rv_execute(input rv32eu_pkg::t_in_item it);
        rv32eu_pkg::t_out_item r;
        logic [31:0] w, ld, a, b, immi, off, v, pc;
        logic [6:0]  opc, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic        ok, has_dest, take;
        w    = it.instruction_word;
        ld   = it.load_data;
        pc   = cur_pc;
        r    = simple_result(pc + 32'd4, rv32eu_pkg::StDone);
        ok   = 1'b1;
        has_dest = 1'b0;
        take = 1'b0;
        v    = '0;
        opc  = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        rs1  = w[19:15];
        rs2  = w[24:20];
        f7   = w[31:25];
        a    = (32'(rs1) < rv32eu_pkg::RegCount) ? gpr[rs1] : '0;
        b    = (32'(rs2) < rv32eu_pkg::RegCount) ? gpr[rs2] : '0;
        immi = {{20{w[31]}}, w[31:20]};

        if (it.kind) begin
            // Load data from the bus.
            r.next_pc = pc;
            if (!ld_wait) begin
                r.status = rv32eu_pkg::StUnexp;
            end else begin
                case (ld_f3)
                    F3_LB:   v = {{24{ld[7]}}, ld[7:0]};
                    F3_LH:   v = {{16{ld[15]}}, ld[15:0]};
                    F3_LBU:  v = {24'd0, ld[7:0]};
                    F3_LHU:  v = {16'd0, ld[15:0]};
                    default: v = ld;
                endcase
                rd       = ld_rd;
                has_dest = 1'b1;
                ld_wait  = 1'b0;
                r.status = rv32eu_pkg::StLoadDone;
            end
        end else if (ld_wait) begin
            // Instruction arriving while a load is outstanding is dropped.
            r.next_pc = pc;
            r.status  = rv32eu_pkg::StBusy;
        end else begin
            case (opc)
                OPC_REG: begin
                    v = alu_calc(f3, f7, 1'b1, a, b, ok);
                    has_dest = ok;
                end
                OPC_IMM: begin
                    if (f3 == F3_SLL || f3 == F3_SR)
                        v = alu_calc(f3, f7, 1'b0, a, {27'd0, w[24:20]}, ok);
                    else
                        v = alu_calc(f3, F7_BASE, 1'b0, a, immi, ok);
                    has_dest = ok;
                end
                OPC_LUI: begin
                    v = {w[31:12], 12'd0};
                    has_dest = 1'b1;
                end
                OPC_AUIPC: begin
                    v = pc + {w[31:12], 12'd0};
                    has_dest = 1'b1;
                end
                OPC_JAL: begin
                    off = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
                    r.next_pc = pc + off;
                    v = pc + 32'd4;
                    has_dest = 1'b1;
                end
                OPC_JALR: begin
                    if (f3 != 3'd0) begin
                        ok = 1'b0;
                    end else begin
                        r.next_pc = (a + immi) & ~32'd1;
                        v = pc + 32'd4;
                        has_dest = 1'b1;
                    end
                end
                OPC_BRANCH: begin
                    off = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
                    case (f3)
                        F3_BEQ:  take = (a == b);
                        F3_BNE:  take = (a != b);
                        F3_BLT:  take = ($signed(a) < $signed(b));
                        F3_BGE:  take = ($signed(a) >= $signed(b));
                        F3_BLTU: take = (a < b);
                        F3_BGEU: take = (a >= b);
                        default: ok = 1'b0;
                    endcase
                    if (take) r.next_pc = pc + off;
                end
                OPC_LOAD: begin
                    if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
                        ok = 1'b0;
                    end else begin
                        r.mem_op      = rv32eu_pkg::MemRead;
                        r.mem_address = a + immi;
                        r.mem_size    = f3[1:0];
                        ld_wait = 1'b1;
                        ld_rd   = rd;
                        ld_f3   = f3;
                    end
                end
                OPC_STORE: begin
                    if (f3 > F3_SW) begin
                        ok = 1'b0;
                    end else begin
                        r.mem_op      = rv32eu_pkg::MemWrite;
                        r.mem_address = a + {{20{w[31]}}, w[31:25], w[11:7]};
                        r.mem_size    = f3[1:0];
                        case (f3)
                            F3_SB:   r.mem_write_data = {24'd0, b[7:0]};
                            F3_SH:   r.mem_write_data = {16'd0, b[15:0]};
                            default: r.mem_write_data = b;
                        endcase
                    end
                end
                OPC_FENCE: begin
                    if (f3 != 3'd0) ok = 1'b0;
                end
                default: ok = 1'b0;
            endcase
            if (!ok) begin
                r.next_pc = pc + 32'd4;
                has_dest  = 1'b0;
                r.status  = rv32eu_pkg::StUnknown;
            end
            cur_pc = r.next_pc;
        end

        // x0 and indexes past the file are never written.
        if (has_dest && rd != 5'd0 && 32'(rd) < rv32eu_pkg::RegCount) begin
            gpr[rd]        = v;
            r.dest_written = 1'b1;
            r.dest_reg     = rd;
            r.dest_value   = v;
        end
        return r;
    endfunction

    function automatic string fmt_result(input rv32eu_pkg::t_out_item r);
        return $sformatf("pc=%h op=%0d addr=%h wdata=%h size=%0d wr=%0d rd=%0d val=%h st=%0d",
                         r.next_pc, r.mem_op, r.mem_address, r.mem_write_data, r.mem_size,
                         r.dest_written, r.dest_reg, r.dest_value, r.status);
    endfunction

    // Registers are biased toward x0..x7 so that results feed later instructions.
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(99) < 70) return 5'($urandom_range(7));
        return 5'($urandom_range(31));
    endfunction

    // Mostly well-formed instructions with random fields, a little pure noise.
    function automatic logic [31:0] random_word();
        logic [31:0] noise;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [2:0]  load_codes [5];
        int          pick;
        load_codes = '{F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU};
        noise = $urandom;
        f3    = noise[14:12];
        f7    = ($urandom_range(9) == 0) ? noise[31:25] :
                ($urandom_range(1) == 0) ? F7_ALT : F7_BASE;
        pick  = $urandom_range(99);
        if (pick < 20) return enc_r(f7, pick_reg(), pick_reg(), f3, pick_reg());
        if (pick < 40) begin
            if (f3 == F3_SLL || f3 == F3_SR)
                return enc_i({f7, noise[24:20]}, pick_reg(), f3, pick_reg(), OPC_IMM);
            return enc_i(noise[31:20], pick_reg(), f3, pick_reg(), OPC_IMM);
        end
        if (pick < 45) return enc_u(noise[31:12], pick_reg(), OPC_LUI);
        if (pick < 50) return enc_u(noise[31:12], pick_reg(), OPC_AUIPC);
        if (pick < 55) return enc_j(noise[20:0], pick_reg());
        if (pick < 60) begin
            if ($urandom_range(9) != 0) f3 = 3'd0;
            return enc_i(noise[31:20], pick_reg(), f3, pick_reg(), OPC_JALR);
        end
        if (pick < 72) return enc_b(noise[12:0], pick_reg(), pick_reg(), f3);
        if (pick < 84) begin
            if ($urandom_range(9) != 0) f3 = load_codes[$urandom_range(4)];
            return enc_i(noise[31:20], pick_reg(), f3, pick_reg(), OPC_LOAD);
        end
        if (pick < 94) begin
            if ($urandom_range(9) != 0) f3 = 3'($urandom_range(2));
            return enc_s(noise[31:20], pick_reg(), pick_reg(), f3);
        end
        if (pick < 96) begin
            if ($urandom_range(3) != 0) f3 = 3'd0;
            return {noise[31:15], f3, noise[11:7], OPC_FENCE};
        end
        return noise;
    endfunction

    task automatic add_row(input logic kind, input logic [31:0] word, input logic [31:0] data,
                           input logic typed, input rv32eu_pkg::t_out_item fixed);
        t_stim_row row;
        row.item.kind             = kind;
        row.item.instruction_word = word;
        row.item.load_data        = data;
        row.typed                 = typed;
        row.fixed                 = fixed;
        dir_rows.push_back(row);
    endtask

    // Presents one item, holding it until accepted, then records its expected result.
    task automatic send_item(input rv32eu_pkg::t_in_item it, input logic typed,
                             input rv32eu_pkg::t_out_item fixed);
        rv32eu_pkg::t_out_item want;
        while (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        want = rv_execute(it);
        pending_results.push_back(typed ? fixed : want);
    endtask

    // Holds the sender off until every outstanding result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_start(input logic [31:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_pc = addr;
    endtask

    // Result side: random stall, compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        rv32eu_pkg::t_out_item want;
        rv32eu_pkg::t_out_item got;
        logic                  bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_item;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result with nothing expected: %s", fmt_result(got));
            end else begin
                want = pending_results.pop_front();
                bad = (got.next_pc !== want.next_pc) || (got.mem_op !== want.mem_op) ||
                      (got.mem_address !== want.mem_address) ||
                      (got.mem_write_data !== want.mem_write_data) ||
                      (got.mem_size !== want.mem_size) ||
                      (got.dest_written !== want.dest_written) ||
                      (got.dest_reg !== want.dest_reg) ||
                      (got.dest_value !== want.dest_value) || (got.status !== want.status);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch expected: %s", fmt_result(want));
                        $display("         actual:   %s", fmt_result(got));
                    end
                end
            end
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        rv32eu_pkg::t_in_item it;
        logic [31:0]          start_values [PHASES];
        int                   counted;
        int                   ph;
        start_values = '{32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h8000_0000, $urandom, $urandom};

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycles      = 0;
        calm        = 1'b0;
        for (int k = 0; k < 32; k++) gpr[k] = '0;
        cur_pc  = '0;
        ld_wait = 1'b0;
        ld_rd   = '0;
        ld_f3   = '0;

        // Directed table; typed rows run from a program counter of zero.
        add_row(1'b1, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1,
                simple_result(32'd0, rv32eu_pkg::StUnexp));
        add_row(1'b0, 32'h0000_0000, 32'h0, 1'b1,
                simple_result(32'd4, rv32eu_pkg::StUnknown));
        add_row(1'b0, WORD_ECALL, 32'h0, 1'b1,
                simple_result(32'd8, rv32eu_pkg::StUnknown));
        add_row(1'b0, enc_i({F7_ALT, 5'd3}, 5'd1, F3_SLL, 5'd2, OPC_IMM), 32'h0,
                1'b1, simple_result(32'd12, rv32eu_pkg::StUnknown));
        add_row(1'b0, enc_u(20'hFFFFF, 5'd1, OPC_LUI), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_i(12'h800, 5'd0, F3_ADD, 5'd2, OPC_IMM), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_i(12'h7FF, 5'd0, F3_ADD, 5'd3, OPC_IMM), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_BASE, 5'd3, 5'd1, F3_ADD, 5'd4), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_ALT, 5'd1, 5'd2, F3_ADD, 5'd5), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd6), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_i({F7_ALT, 5'd4}, 5'd2, F3_SR, 5'd7, OPC_IMM), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd8), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd9), 32'h0, 1'b0, '0);
        // Write to x0 executes but leaves nothing behind.
        add_row(1'b0, enc_i(12'd5, 5'd3, F3_ADD, 5'd0, OPC_IMM), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_u(20'h80000, 5'd10, OPC_AUIPC), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_s(12'h800, 5'd1, 5'd3, F3_SW), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_s(12'h7FF, 5'd2, 5'd0, F3_SB), 32'h0, 1'b0, '0);
        // Load, an instruction while it waits, then its data.
        add_row(1'b0, enc_i(12'd0, 5'd3, F3_LB, 5'd11, OPC_LOAD), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_r(F7_BASE, 5'd1, 5'd1, F3_ADD, 5'd12), 32'h0, 1'b0, '0);
        add_row(1'b1, 32'h0, 32'h0000_0080, 1'b0, '0);
        // Load into x0 still goes to the bus and waits.
        add_row(1'b0, enc_i(12'd4, 5'd1, F3_LHU, 5'd0, OPC_LOAD), 32'h0, 1'b0, '0);
        add_row(1'b1, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
        add_row(1'b0, enc_b(13'h1000, 5'd3, 5'd2, F3_BLT), 32'h0, 1'b0, '0);
        add_row(1'b0, enc_j(21'h0F_FFFE, 5'd13), 32'h0, 1'b0, '0);
        // JALR with an odd target drops bit zero.
        add_row(1'b0, enc_i(12'd1, 5'd2, 3'd0, 5'd14, OPC_JALR), 32'h0, 1'b0, '0);
        add_row(1'b0, {25'd0, OPC_FENCE}, 32'h0, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_start(32'h0000_0000);
        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].fixed);
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        // Random phases, each from its own start address; one phase runs without gaps.
        for (ph = 0; ph < PHASES; ph++) begin
            calm = (ph == 2);
            write_start(start_values[ph]);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it.load_data        = $urandom;
                it.instruction_word = random_word();
                if (ld_wait) it.kind = ($urandom_range(99) < 85);
                else         it.kind = ($urandom_range(99) < 4);
                if (it.kind == ld_wait) counted++;
                send_item(it, 1'b0, '0);
                if (it.kind == ld_wait && counted == PHASE_ITEMS / 2) drain_results();
            end
            drain_results();
            repeat (DRAIN_CYCLES) @(posedge i_clk);
        end
        calm = 1'b0;

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/rv32eu_pkg.sv
rtl/rv32eu_exec.sv
rtl/rv32execute_unit_core.sv
test/rv32i_execute_unit_core_tb.sv
